/* rtl/mwsm_pkg.sv */
// Shared constants and types for the mecanum wheel speed mixer.
// Used by mecanum_wheel_speed_mixer_top; no dependencies.

package mwsm_pkg;

  // default parameter values
  localparam int SPEED_WIDTH_DEF = 16;
  localparam int RATIO_FRAC_DEF  = 24;

  localparam int NUM_WHEELS = 4;

  // configuration register widths
  localparam int LIMIT_W   = 15;  // clamp limits and wheel rpm limit
  localparam int ROT_W     = 16;  // Q8.8 rotate terms
  localparam int REG_IDX_W = 3;

  // datapath widths, fixed by the register widths
  localparam int CLAMP_W  = 16;  // clamped axis value, signed
  localparam int LIN_W    = 17;  // +-vx +-vy, signed
  localparam int RR_W     = 18;  // per-wheel rotate ratio, signed Q8.8
  localparam int PROD_W   = 34;  // vw * ratio, signed
  localparam int TERM_W   = 35;  // wheel term in Q8.8, signed
  localparam int MAG_W    = 33;  // magnitude of the wheel term
  localparam int MAG_LO_W = 17;  // low slice for the split multiply
  localparam int MAG_HI_W = MAG_W - MAG_LO_W;
  localparam int WMAG_W   = 25;  // unscaled wheel rpm magnitude
  localparam int QUOT_W   = LIMIT_W;  // scaled rpm magnitude
  localparam int NUM_W    = WMAG_W + LIMIT_W;  // dividend of the limiter

  // register reset values
  localparam int MAX_LIN_X_RST   = 4000;
  localparam int MAX_LIN_Y_RST   = 4000;
  localparam int MAX_ROT_RST     = 300;
  localparam int ROTATE_BASE_RST = 2560;
  localparam int RPM_RATIO_RST   = 110000;
  localparam int RPM_CAP_RST     = 8000;

  // register map
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAX_LIN_X   = 3'd0,
    REG_MAX_LIN_Y   = 3'd1,
    REG_MAX_ROT     = 3'd2,
    REG_ROTATE_BASE = 3'd3,
    REG_ROTATE_X    = 3'd4,
    REG_ROTATE_Y    = 3'd5,
    REG_RPM_RATIO   = 3'd6,
    REG_RPM_CAP     = 3'd7
  } mwsm_reg_e;

endpackage

/* rtl/mecanum_wheel_speed_mixer_top.sv */
// Mecanum wheel speed mixer: clamp, inverse kinematics, proportional limiting.
// Depends on mwsm_pkg.
//
// Usage:
//   s_axis carries one chassis command word per beat (speed_x, speed_y,
//   speed_w). m_axis returns one word of four wheel speeds, with the
//   was_scaled flag on tuser. The cfg channel writes one register per beat
//   and is always ready; write it only while the pipeline is empty.
// Timing:
//   22 register stages: clamp, mix, term, split multiply, rpm, peak/limit
//   multiply, 15 divider steps (one quotient bit each), output. One word
//   per cycle is accepted and delivered while m_axis_tready is high; the
//   divider step chain sets the latency, the split rpm multiply sets the
//   stage count ahead of it.
// Reset:
//   rst_ni clears all valid bits and loads register defaults.
// Backpressure:
//   Each stage holds its own valid bit, so bubbles close up while m_axis is
//   stalled; s_axis_tready drops only once all 22 stages hold a word.

module mecanum_wheel_speed_mixer_top
  import mwsm_pkg::*;
#(
  parameter int SPEED_WIDTH     = SPEED_WIDTH_DEF,
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // command stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: speed_x, speed_y, speed_w
  input  logic [((3*SPEED_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // wheel speed stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: rpm_front_left, rpm_front_right, rpm_back_left, rpm_back_right
  output logic [((4*SPEED_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // tuser: was_scaled
  output logic                   m_axis_tuser,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [REG_IDX_W-1:0]   cfg_index_i,
  input  logic [((RATIO_FRAC_BITS > ROT_W) ? RATIO_FRAC_BITS : ROT_W)-1:0] cfg_data_i
);

  localparam int S        = SPEED_WIDTH;
  localparam int F        = RATIO_FRAC_BITS;
  localparam int OUT_W    = ((4*S + 7) / 8) * 8;
  localparam int CMP_W    = ((S > CLAMP_W) ? S : CLAMP_W) + 1;
  localparam int SAT_W    = ((S > QUOT_W + 2) ? S : QUOT_W + 2) + 1;
  localparam int PLO_W    = MAG_LO_W + F;
  localparam int PHI_W    = MAG_HI_W + F;
  localparam int PSUM_W   = MAG_W + F + 1;
  localparam int DIV_ST   = QUOT_W;
  localparam int ST_DIV0  = 6;
  localparam int NST      = ST_DIV0 + DIV_ST + 1;
  localparam int ST_OUT   = NST - 1;

  localparam logic [F-1:0] RATIO_RST = F'(RPM_RATIO_RST);
  localparam logic signed [SAT_W-1:0] OUT_HI = {{(SAT_W-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] OUT_LO = ~OUT_HI;

  // ---------------------------------------------------------------------
  // configuration registers
  logic [LIMIT_W-1:0]       max_lin_x_q, max_lin_y_q, max_rot_q, rpm_cap_q;
  logic [ROT_W-1:0]         rotate_base_q;
  logic signed [ROT_W-1:0]  rotate_x_q, rotate_y_q;
  logic [F-1:0]             rpm_ratio_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lin_x_q     <= LIMIT_W'(MAX_LIN_X_RST);
      max_lin_y_q     <= LIMIT_W'(MAX_LIN_Y_RST);
      max_rot_q       <= LIMIT_W'(MAX_ROT_RST);
      rotate_base_q   <= ROT_W'(ROTATE_BASE_RST);
      rotate_x_q      <= '0;
      rotate_y_q      <= '0;
      rpm_ratio_q     <= RATIO_RST;
      rpm_cap_q       <= LIMIT_W'(RPM_CAP_RST);
    end else if (cfg_valid_i) begin
      unique case (mwsm_reg_e'(cfg_index_i))
        REG_MAX_LIN_X:     max_lin_x_q     <= cfg_data_i[LIMIT_W-1:0];
        REG_MAX_LIN_Y:     max_lin_y_q     <= cfg_data_i[LIMIT_W-1:0];
        REG_MAX_ROT:       max_rot_q       <= cfg_data_i[LIMIT_W-1:0];
        REG_ROTATE_BASE:   rotate_base_q   <= cfg_data_i[ROT_W-1:0];
        REG_ROTATE_X:      rotate_x_q      <= $signed(cfg_data_i[ROT_W-1:0]);
        REG_ROTATE_Y:      rotate_y_q      <= $signed(cfg_data_i[ROT_W-1:0]);
        REG_RPM_RATIO:     rpm_ratio_q     <= cfg_data_i[F-1:0];
        REG_RPM_CAP:       rpm_cap_q       <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // per-wheel rotate ratios, registered from the configuration registers
  logic signed [RR_W-1:0] rr_q [NUM_WHEELS];

  always_ff @(posedge clk_i) begin
    logic signed [RR_W-1:0] b, x, y;
    b = $signed({2'b00, rotate_base_q});
    x = RR_W'(rotate_x_q);
    y = RR_W'(rotate_y_q);
    rr_q[0] <= b - x - y;
    rr_q[1] <= b - x + y;
    rr_q[2] <= b + x - y;
    rr_q[3] <= b + x + y;
  end

  // ---------------------------------------------------------------------
  // stage valid bits; a stage loads when m_axis is ready or when it or any
  // later stage is empty
  logic [NST-1:0] vld_q, vld_d;
  logic [NST:0]   adv;

  assign adv[NST] = m_axis_tready;
  for (genvar k = 0; k < NST; k++) begin : g_adv
    assign adv[k] = m_axis_tready | ~(&vld_q[NST-1:k]);
  end

  always_comb begin
    vld_d[0] = adv[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NST; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld_q[ST_OUT];

  // ---------------------------------------------------------------------
  // stage 0: clamp each axis to its limit
  function automatic logic signed [CLAMP_W-1:0] clamp_axis(
    input logic signed [S-1:0] v,
    input logic [LIMIT_W-1:0]  lim
  );
    logic signed [CMP_W-1:0] ve, lp, ln, r;
    ve = CMP_W'(v);
    lp = $signed({{(CMP_W-LIMIT_W){1'b0}}, lim});
    ln = -lp;
    if (ve > lp) begin
      r = lp;
    end else if (ve < ln) begin
      r = ln;
    end else begin
      r = ve;
    end
    return r[CLAMP_W-1:0];
  endfunction

  logic signed [CLAMP_W-1:0] cx_q, cy_q, cw_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      cx_q <= clamp_axis($signed(s_axis_tdata[S-1:0]), max_lin_x_q);
      cy_q <= clamp_axis($signed(s_axis_tdata[2*S-1:S]), max_lin_y_q);
      cw_q <= clamp_axis($signed(s_axis_tdata[3*S-1:2*S]), max_rot_q);
    end
  end

  // stage 1: linear mix and yaw products
  logic signed [LIN_W-1:0]  lin_q  [NUM_WHEELS];
  logic signed [PROD_W-1:0] prod_q [NUM_WHEELS];

  always_ff @(posedge clk_i) begin
    logic signed [LIN_W-1:0] ex, ey;
    ex = LIN_W'(cx_q);
    ey = LIN_W'(cy_q);
    if (adv[1]) begin
      lin_q[0] <= ex + ey;
      lin_q[1] <= ey - ex;
      lin_q[2] <= ex - ey;
      lin_q[3] <= -ex - ey;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        prod_q[i] <= PROD_W'(cw_q) * PROD_W'(rr_q[i]);
      end
    end
  end

  // stage 2: Q8.8 wheel term, split into sign and magnitude
  logic [MAG_W-1:0] mag_q  [NUM_WHEELS];
  logic             neg2_q [NUM_WHEELS];

  always_ff @(posedge clk_i) begin
    logic signed [TERM_W-1:0] term;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      term = (TERM_W'(lin_q[i]) <<< 8) - TERM_W'(prod_q[i]);
      if (adv[2]) begin
        neg2_q[i] <= term[TERM_W-1];
        mag_q[i]  <= term[TERM_W-1] ? MAG_W'(-term) : MAG_W'(term);
      end
    end
  end

  // stage 3: magnitude times rpm ratio, two partial products
  logic [PLO_W-1:0] plo_q  [NUM_WHEELS];
  logic [PHI_W-1:0] phi_q  [NUM_WHEELS];
  logic             neg3_q [NUM_WHEELS];

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        plo_q[i]  <= PLO_W'(mag_q[i][MAG_LO_W-1:0]) * PLO_W'(rpm_ratio_q);
        phi_q[i]  <= PHI_W'(mag_q[i][MAG_W-1:MAG_LO_W]) * PHI_W'(rpm_ratio_q);
        neg3_q[i] <= neg2_q[i];
      end
    end
  end

  // stage 4: combine partials and drop the Q8.F fraction
  logic [WMAG_W-1:0] wmag_q [NUM_WHEELS];
  logic              neg4_q [NUM_WHEELS];

  always_ff @(posedge clk_i) begin
    logic [PSUM_W-1:0] psum;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      psum = (PSUM_W'(phi_q[i]) << MAG_LO_W) + PSUM_W'(plo_q[i]);
      if (adv[4]) begin
        wmag_q[i] <= psum[8+F +: WMAG_W];
        neg4_q[i] <= neg3_q[i];
      end
    end
  end

  // stage 5: peak magnitude, limit test, dividend m * rpm cap
  logic [WMAG_W-1:0]  pk_q;
  logic               scl5_q;
  logic [NUM_W-1:0]   num_q  [NUM_WHEELS];
  logic [QUOT_W-1:0]  wlo5_q [NUM_WHEELS];
  logic               neg5_q [NUM_WHEELS];

  always_ff @(posedge clk_i) begin
    logic [WMAG_W-1:0] m01, m23, pk;
    m01 = (wmag_q[0] > wmag_q[1]) ? wmag_q[0] : wmag_q[1];
    m23 = (wmag_q[2] > wmag_q[3]) ? wmag_q[2] : wmag_q[3];
    pk  = (m01 > m23) ? m01 : m23;
    if (adv[5]) begin
      pk_q   <= pk;
      scl5_q <= pk > WMAG_W'(rpm_cap_q);
      for (int i = 0; i < NUM_WHEELS; i++) begin
        num_q[i]  <= NUM_W'(wmag_q[i]) * NUM_W'(rpm_cap_q);
        wlo5_q[i] <= wmag_q[i][QUOT_W-1:0];
        neg5_q[i] <= neg4_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // divider steps: restoring division by the peak, one quotient bit per
  // stage; the dividend is below peak << QUOT_W so the quotient fits
  logic [WMAG_W-1:0] dr_q   [DIV_ST][NUM_WHEELS];
  logic [QUOT_W-1:0] dn_q   [DIV_ST][NUM_WHEELS];
  logic [QUOT_W-1:0] dq_q   [DIV_ST][NUM_WHEELS];
  logic [QUOT_W-1:0] dw_q   [DIV_ST][NUM_WHEELS];
  logic              dneg_q [DIV_ST][NUM_WHEELS];
  logic [WMAG_W-1:0] dpk_q  [DIV_ST];
  logic              dscl_q [DIV_ST];

  logic [WMAG_W-1:0] dr_in   [DIV_ST][NUM_WHEELS];
  logic [QUOT_W-1:0] dn_in   [DIV_ST][NUM_WHEELS];
  logic [QUOT_W-1:0] dq_in   [DIV_ST][NUM_WHEELS];
  logic [QUOT_W-1:0] dw_in   [DIV_ST][NUM_WHEELS];
  logic              dneg_in [DIV_ST][NUM_WHEELS];
  logic [WMAG_W-1:0] dpk_in  [DIV_ST];
  logic              dscl_in [DIV_ST];

  // source of each step: stage 5 for the first, the previous step after
  always_comb begin
    for (int j = 0; j < DIV_ST; j++) begin
      if (j == 0) begin
        dpk_in[j]  = pk_q;
        dscl_in[j] = scl5_q;
      end else begin
        dpk_in[j]  = dpk_q[j-1];
        dscl_in[j] = dscl_q[j-1];
      end
      for (int i = 0; i < NUM_WHEELS; i++) begin
        if (j == 0) begin
          dr_in[j][i]   = num_q[i][NUM_W-1:QUOT_W];
          dn_in[j][i]   = num_q[i][QUOT_W-1:0];
          dq_in[j][i]   = '0;
          dw_in[j][i]   = wlo5_q[i];
          dneg_in[j][i] = neg5_q[i];
        end else begin
          dr_in[j][i]   = dr_q[j-1][i];
          dn_in[j][i]   = dn_q[j-1][i];
          dq_in[j][i]   = dq_q[j-1][i];
          dw_in[j][i]   = dw_q[j-1][i];
          dneg_in[j][i] = dneg_q[j-1][i];
        end
      end
    end
  end

  // shift in the next dividend bit, subtract the peak where it fits
  always_ff @(posedge clk_i) begin
    logic [WMAG_W:0] t;
    logic [WMAG_W:0] diff;
    logic            ge;
    for (int j = 0; j < DIV_ST; j++) begin
      if (adv[ST_DIV0+j]) begin
        dpk_q[j]  <= dpk_in[j];
        dscl_q[j] <= dscl_in[j];
      end
      for (int i = 0; i < NUM_WHEELS; i++) begin
        t    = {dr_in[j][i], dn_in[j][i][QUOT_W-1]};
        diff = t - {1'b0, dpk_in[j]};
        ge   = t >= {1'b0, dpk_in[j]};
        if (adv[ST_DIV0+j]) begin
          dr_q[j][i]   <= ge ? diff[WMAG_W-1:0] : t[WMAG_W-1:0];
          dn_q[j][i]   <= dn_in[j][i] << 1;
          dq_q[j][i]   <= {dq_in[j][i][QUOT_W-2:0], ge};
          dw_q[j][i]   <= dw_in[j][i];
          dneg_q[j][i] <= dneg_in[j][i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // output stage: pick scaled or plain magnitude, restore sign, saturate
  logic [S-1:0] rpm_q [NUM_WHEELS];
  logic         scl_out_q;

  always_ff @(posedge clk_i) begin
    logic [QUOT_W-1:0]       m;
    logic signed [SAT_W-1:0] ext, val;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      m   = dscl_q[DIV_ST-1] ? dq_q[DIV_ST-1][i] : dw_q[DIV_ST-1][i];
      ext = $signed(SAT_W'(m));
      val = dneg_q[DIV_ST-1][i] ? -ext : ext;
      if (val > OUT_HI) begin
        val = OUT_HI;
      end else if (val < OUT_LO) begin
        val = OUT_LO;
      end
      if (adv[ST_OUT]) begin
        rpm_q[i] <= val[S-1:0];
      end
    end
    if (adv[ST_OUT]) begin
      scl_out_q <= dscl_q[DIV_ST-1];
    end
  end

  assign m_axis_tdata = OUT_W'({rpm_q[3], rpm_q[2], rpm_q[1], rpm_q[0]});
  assign m_axis_tuser = scl_out_q;

endmodule
